/* hw/rtl/round_robin_quantum_scheduler_macros.svh */
// ----------------------------------------------------------------------------
// Round-robin quantum scheduler assertion macros
// Shared property wrappers for the port checker.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH
`define ROUND_ROBIN_QUANTUM_SCHEDULER_MACROS_SVH

// Implication checked every cycle outside reset.
`define RRQS_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define RRQS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/rrqs_pkg.sv */
// ----------------------------------------------------------------------------
// rrqs_pkg
// Request, result and process record types for the quantum scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package rrqs_pkg;

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_RUN  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [6:0]  process_id;
    logic [31:0] arrival_time;
    logic [31:0] burst_time;
    logic [31:0] first_response_offset;
  } req_t;

  typedef struct packed {
    logic        slice_valid;
    logic [6:0]  process_id_res;
    logic [31:0] slice_start;
    logic [31:0] slice_end;
    logic        finished;
    logic [31:0] turnaround;
    logic [31:0] wait_time;
    logic        response_valid;
    logic [31:0] response_time;
    logic        last;
  } res_t;

  // one entry of the process table
  typedef struct packed {
    logic [31:0] arrival;
    logic [31:0] remaining;
    logic [31:0] countdown;
    logic [31:0] service;
    logic [6:0]  ident;
    logic        responded;
  } rec_t;

  // ready ring control
  typedef struct packed {
    logic push;
    logic pop;
  } ring_op_t;

endpackage

`default_nettype wire

/* hw/rtl/rrqs_alu.sv */
// ----------------------------------------------------------------------------
// rrqs_alu
// Shared 32-bit add/subtract unit with carry, reused by every slice step.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_alu (
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  input  wire logic        sub,
  output logic [31:0]      y,
  output logic             carry
);

  logic [32:0] sum;

  // on subtract, carry high means a >= b
  assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {32'd0, sub};
  assign y     = sum[31:0];
  assign carry = sum[32];

endmodule

`default_nettype wire

/* hw/rtl/rrqs_ring.sv */
// ----------------------------------------------------------------------------
// rrqs_ring
// Ready queue of process slots held in a circular memory.
// ----------------------------------------------------------------------------
`default_nettype none

module rrqs_ring #(
  parameter int MAX_PROCS = 64
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire rrqs_pkg::ring_op_t               op,
  input  wire logic [$clog2(MAX_PROCS)-1:0]     wslot,
  output logic [$clog2(MAX_PROCS)-1:0]          rslot,
  output logic [$clog2(MAX_PROCS+1)-1:0]        count
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  logic [AW-1:0] ring_mem [MAX_PROCS];
  logic [AW-1:0] head;
  logic [CW:0]   tail_sum;
  logic [AW-1:0] tail;

  // tail = (head + count) mod depth
  always_comb begin
    tail_sum = (CW+1)'(head) + (CW+1)'(count);
    if (tail_sum >= (CW+1)'(MAX_PROCS)) begin
      tail_sum = tail_sum - (CW+1)'(MAX_PROCS);
    end
    tail = tail_sum[AW-1:0];
  end

  // storage, read data registered
  always_ff @(posedge clk) begin
    if (op.push && count < CW'(MAX_PROCS)) begin
      ring_mem[tail] <= wslot;
    end
    rslot <= ring_mem[head];
  end

  // head and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (op.push) begin
      if (count < CW'(MAX_PROCS)) begin
        count <= count + CW'(1);
      end
    end else if (op.pop) begin
      head  <= (head == AW'(MAX_PROCS - 1)) ? '0 : head + AW'(1);
      count <= count - CW'(1);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/round_robin_quantum_scheduler.sv */
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler
// Round-robin time-slice scheduler with a programmable quantum.
// ----------------------------------------------------------------------------
// Channel | Direction | Payload          | Handshake
// in      | input     | rrqs_pkg::req_t  | in_valid / in_ready
// out     | output    | rrqs_pkg::res_t  | out_valid / out_ready
// cfg     | input     | 16-bit quantum   | cfg_valid / cfg_ready
//
// A load request is written to the process table while idle. For a run request
// the shared adder serializes the ten arithmetic steps and the single read port
// of the process table serializes the lookups.
// Reset is synchronous; no clearing pass is needed. A stalled result holds
// the block busy until out_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_quantum_scheduler #(
  parameter int MAX_PROCS = 64
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire rrqs_pkg::req_t  in_data,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output rrqs_pkg::res_t       out_data,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [15:0]     cfg_data
);

  localparam int AW = $clog2(MAX_PROCS);
  localparam int CW = $clog2(MAX_PROCS + 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_POP   = 4'd1;
  localparam logic [3:0] S_JUMP  = 4'd2;
  localparam logic [3:0] S_RING  = 4'd3;
  localparam logic [3:0] S_FETCH = 4'd4;
  localparam logic [3:0] S_CALC  = 4'd5;
  localparam logic [3:0] S_ADMRD = 4'd6;
  localparam logic [3:0] S_ADMCK = 4'd7;
  localparam logic [3:0] S_REQ   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  localparam logic [3:0] STEP_LAST = 4'd9;

  logic [3:0]         state;
  logic [3:0]         step;
  logic [15:0]        quantum;
  logic [CW-1:0]      loaded;
  logic [CW-1:0]      admit;
  logic [AW-1:0]      p;
  logic [31:0]        cur_time;
  logic [31:0]        start;
  logic [31:0]        run;
  logic [31:0]        end_t;
  logic [31:0]        tmp;
  logic [31:0]        turn;
  logic [31:0]        wt;
  logic [31:0]        resp_time;
  logic               fin;
  logic               resp;
  rrqs_pkg::rec_t     rec;
  rrqs_pkg::rec_t     rd;
  rrqs_pkg::rec_t     wdata;
  rrqs_pkg::rec_t     tbl [MAX_PROCS];
  logic [AW-1:0]      raddr;
  logic [AW-1:0]      waddr;
  logic               wen;
  rrqs_pkg::res_t     res;
  rrqs_pkg::ring_op_t rop;
  logic [AW-1:0]      rwslot;
  logic [AW-1:0]      rslot;
  logic [CW-1:0]      rcount;
  logic [31:0]        q;
  logic [31:0]        alu_a;
  logic [31:0]        alu_b;
  logic               alu_sub;
  logic [31:0]        alu_y;
  logic               alu_c;
  logic [31:0]        sat;
  logic               more;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (state == S_OUT);
  assign out_data  = res;
  assign q         = (quantum == 16'd0) ? 32'd1 : {16'd0, quantum};
  assign sat       = alu_c ? alu_y : 32'd0;
  assign more      = (admit < loaded);

  rrqs_alu u_alu (
    .a     (alu_a),
    .b     (alu_b),
    .sub   (alu_sub),
    .y     (alu_y),
    .carry (alu_c)
  );

  rrqs_ring #(.MAX_PROCS(MAX_PROCS)) u_ring (
    .clk   (clk),
    .rst   (rst),
    .op    (rop),
    .wslot (rwslot),
    .rslot (rslot),
    .count (rcount)
  );

  // quantum register
  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= 16'd4;
    end else if (cfg_valid && cfg_ready) begin
      quantum <= cfg_data;
    end
  end

  // operand select for the shared adder
  always_comb begin
    alu_a   = 32'd0;
    alu_b   = 32'd0;
    alu_sub = 1'b1;
    unique case (step)
      4'd0: begin alu_a = q;         alu_b = rec.remaining; end
      4'd1: begin alu_a = ~cur_time; alu_b = run; end
      4'd2: begin alu_a = cur_time;  alu_b = run; alu_sub = 1'b0; end
      4'd3: begin alu_a = rec.remaining; alu_b = run; end
      4'd4: begin alu_a = rec.service; alu_b = run; alu_sub = 1'b0; end
      4'd5: begin alu_a = run;       alu_b = rec.countdown; end
      4'd6: begin
        alu_a   = resp ? start : rec.countdown;
        alu_b   = resp ? rec.countdown : run;
        alu_sub = !resp;
      end
      4'd7: begin alu_a = tmp;       alu_b = rec.arrival; end
      4'd8: begin alu_a = end_t;     alu_b = rec.arrival; end
      4'd9: begin alu_a = turn;      alu_b = rec.service; end
      default: begin alu_a = 32'd0;  alu_b = 32'd0; end
    endcase
  end

  // table ports and ring requests
  always_comb begin
    raddr  = admit[AW-1:0];
    waddr  = loaded[AW-1:0];
    wdata  = rec;
    wen    = 1'b0;
    rop    = '0;
    rwslot = admit[AW-1:0];
    priority case (state)
      S_IDLE: begin
        wdata.arrival   = in_data.arrival_time;
        wdata.remaining = in_data.burst_time;
        wdata.countdown = in_data.first_response_offset;
        wdata.service   = 32'd0;
        wdata.ident     = in_data.process_id;
        wdata.responded = 1'b0;
        wen = in_valid && in_data.req_type == rrqs_pkg::REQ_LOAD &&
              loaded < CW'(MAX_PROCS);
      end
      S_POP:   rop.pop = (rcount != '0);
      S_RING:  raddr = rslot;
      S_CALC: begin
        waddr = p;
        wen   = (step == STEP_LAST);
      end
      S_ADMCK: rop.push = (rd.arrival < end_t);
      S_REQ: begin
        rop.push = !fin;
        rwslot   = p;
      end
      default: ;
    endcase
  end

  // process table
  always_ff @(posedge clk) begin
    if (wen) begin
      tbl[waddr] <= wdata;
    end
    rd <= tbl[raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      step     <= 4'd0;
      loaded   <= '0;
      admit    <= '0;
      cur_time <= 32'd0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (in_data.req_type == rrqs_pkg::REQ_RUN) begin
              state <= S_POP;
            end else if (loaded < CW'(MAX_PROCS)) begin
              loaded <= loaded + CW'(1);
            end
          end
        end
        S_POP: begin
          if (rcount != '0) begin
            state <= S_RING;
          end else if (!more) begin
            // no work left: empty result marked last
            res   <= '{last: 1'b1, default: '0};
            state <= S_OUT;
          end else begin
            state <= S_JUMP;
          end
        end
        // empty queue: jump to the next arrival and run it directly
        S_JUMP: begin
          if (rd.arrival > cur_time) begin
            cur_time <= rd.arrival;
          end
          p     <= admit[AW-1:0];
          admit <= admit + CW'(1);
          rec   <= rd;
          step  <= 4'd0;
          state <= S_CALC;
        end
        S_RING: begin
          p     <= rslot;
          state <= S_FETCH;
        end
        S_FETCH: begin
          rec   <= rd;
          step  <= 4'd0;
          state <= S_CALC;
        end
        // slice arithmetic, one adder step per cycle
        S_CALC: begin
          step <= step + 4'd1;
          unique case (step)
            4'd0: begin
              start <= cur_time;
              fin   <= alu_c;
              run   <= alu_c ? rec.remaining : q;
              resp  <= 1'b0;
            end
            4'd1: begin
              if (!alu_c) begin
                run <= ~cur_time;
                fin <= (~cur_time == rec.remaining);
              end
            end
            4'd2: end_t <= alu_y;
            4'd3: rec.remaining <= alu_y;
            4'd4: rec.service <= alu_y;
            4'd5: resp <= !rec.responded && alu_c;
            4'd6: begin
              if (resp) begin
                tmp <= alu_y;
              end else if (!rec.responded) begin
                rec.countdown <= alu_y;
              end
            end
            4'd7: begin
              resp_time <= resp ? sat : 32'd0;
              if (resp) begin
                rec.responded <= 1'b1;
                rec.countdown <= 32'd0;
              end
            end
            4'd8: turn <= sat;
            4'd9: begin
              wt       <= sat;
              cur_time <= end_t;
              state    <= S_ADMRD;
            end
            default: state <= S_ADMRD;
          endcase
        end
        // admit arrivals strictly before the slice end
        S_ADMRD: state <= more ? S_ADMCK : S_REQ;
        S_ADMCK: begin
          if (rd.arrival < end_t) begin
            admit <= admit + CW'(1);
            state <= S_ADMRD;
          end else begin
            state <= S_REQ;
          end
        end
        S_REQ: state <= S_FIN;
        S_FIN: begin
          res.slice_valid    <= 1'b1;
          res.process_id_res <= rec.ident;
          res.slice_start    <= start;
          res.slice_end      <= end_t;
          res.finished       <= fin;
          res.turnaround     <= turn;
          res.wait_time      <= wt;
          res.response_valid <= resp;
          res.response_time  <= resp_time;
          res.last           <= (rcount == '0) && !more;
          state              <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/rrqs_checker.sv */
// ----------------------------------------------------------------------------
// rrqs_checker
// Port-level checks for the quantum scheduler, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "round_robin_quantum_scheduler_macros.svh"

module rrqs_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_ready,
  input wire logic           out_valid,
  input wire logic           out_ready,
  input wire rrqs_pkg::res_t out_data
);

  // stalled result holds
  `RRQS_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // no new request taken while a result waits
  `RRQS_ASSERT_IMPL(a_busy_out, clk, rst, out_valid, !in_ready, "input ready with pending result")

  // an empty result always marks the end of work
  `RRQS_ASSERT_IMPL(a_idle_last, clk, rst, out_valid && !out_data.slice_valid, out_data.last && !out_data.finished, "empty result without last")

  // a slice never ends before it starts
  `RRQS_ASSERT_IMPL(a_order, clk, rst, out_valid && out_data.slice_valid, out_data.slice_end >= out_data.slice_start, "slice end before start")

endmodule

bind round_robin_quantum_scheduler rrqs_checker u_rrqs_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* tb/round_robin_quantum_scheduler_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// round_robin_quantum_scheduler_checker
// Watches the request, result and quantum channels of the scheduler. It keeps
// its own process table, ready ring and clock and works out each slice when a
// run request is accepted. Every accepted result is compared field by field
// with the oldest slice still waiting.
// ----------------------------------------------------------------------------
module round_robin_quantum_scheduler_checker
  import rrqs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  req_t        in_data,
  input  logic        out_valid,
  input  logic        out_ready,
  input  res_t        out_data,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [15:0] cfg_data,
  output int          errors,
  output int          pending,
  output int          slices_checked
);

  localparam int NPROC = 64;

  // scheduler shadow state
  logic [31:0] arr_tab [NPROC];
  logic [31:0] rem_tab [NPROC];
  logic [31:0] cd_tab  [NPROC];
  logic [31:0] svc_tab [NPROC];
  logic [6:0]  id_tab  [NPROC];
  bit          responded [NPROC];
  logic [5:0]  ring [NPROC];
  int          ring_head, ring_count, admit_idx, loaded;
  logic [31:0] now;
  logic [15:0] quantum;

  res_t slices_due [$];

  function automatic logic [31:0] floor_sub(logic [31:0] a, logic [31:0] b);
    return (a > b) ? a - b : 32'd0;
  endfunction

  function automatic void ring_push(int slot);
    if (ring_count < NPROC) begin
      ring[(ring_head + ring_count) % NPROC] = slot[5:0];
      ring_count++;
    end
  endfunction

  // store one process record; loads past a full table are dropped
  function automatic void load_proc(req_t r);
    if (loaded < NPROC) begin
      id_tab[loaded]    = r.process_id;
      arr_tab[loaded]   = r.arrival_time;
      rem_tab[loaded]   = r.burst_time;
      cd_tab[loaded]    = r.first_response_offset;
      svc_tab[loaded]   = '0;
      responded[loaded] = 1'b0;
      loaded++;
    end
  endfunction

  // run one slice for the ring head
  function automatic res_t run_slice();
    res_t        r;
    int          p;
    logic [31:0] start, stop, run, q, cd, turn;
    bit          fin;
    r = '0;
    if (ring_count == 0) begin
      if (admit_idx >= loaded) begin
        r.last = 1'b1;
        return r;
      end
      // idle ring: jump ahead to the next arrival
      if (arr_tab[admit_idx] > now) now = arr_tab[admit_idx];
      ring_push(admit_idx);
      admit_idx++;
    end
    p = ring[ring_head];
    ring_head = (ring_head + 1) % NPROC;
    ring_count--;
    start = now;
    q = (quantum == 0) ? 32'd1 : {16'd0, quantum};
    fin = rem_tab[p] <= q;
    run = fin ? rem_tab[p] : q;
    // saturate at the top of the time range
    if (run > ~start) begin
      run = ~start;
      fin = (run == rem_tab[p]);
    end
    stop = start + run;
    rem_tab[p] -= run;
    svc_tab[p] += run;
    now = stop;
    if (!responded[p]) begin
      cd = cd_tab[p];
      if (cd <= run) begin
        r.response_valid = 1'b1;
        r.response_time  = floor_sub(start + cd, arr_tab[p]);
        responded[p] = 1'b1;
        cd_tab[p] = '0;
      end else begin
        cd_tab[p] = cd - run;
      end
    end
    // arrivals before the slice end go ahead of the requeued process
    while (admit_idx < loaded && arr_tab[admit_idx] < stop) begin
      ring_push(admit_idx);
      admit_idx++;
    end
    if (!fin) ring_push(p);
    turn = floor_sub(stop, arr_tab[p]);
    r.slice_valid    = 1'b1;
    r.process_id_res = id_tab[p];
    r.slice_start    = start;
    r.slice_end      = stop;
    r.finished       = fin;
    r.turnaround     = turn;
    r.wait_time      = floor_sub(turn, svc_tab[p]);
    r.last           = (ring_count == 0 && admit_idx >= loaded);
    return r;
  endfunction

  task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  assign pending = slices_due.size();

  always @(posedge clk) begin
    res_t e;
    if (rst) begin
      ring_head  = 0;
      ring_count = 0;
      admit_idx  = 0;
      loaded     = 0;
      now        = '0;
      quantum    = 16'd4;
      foreach (responded[i]) responded[i] = 1'b0;
      slices_due.delete();
      errors = 0;
      slices_checked = 0;
    end else begin
      // results first: they belong to earlier requests
      if (out_valid && out_ready) begin
        if (slices_due.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected: actual %p", $time, out_data);
        end else begin
          e = slices_due.pop_front();
          slices_checked++;
          check_field("slice_valid", e.slice_valid, out_data.slice_valid);
          check_field("process_id_res", e.process_id_res, out_data.process_id_res);
          check_field("slice_start", e.slice_start, out_data.slice_start);
          check_field("slice_end", e.slice_end, out_data.slice_end);
          check_field("finished", e.finished, out_data.finished);
          check_field("turnaround", e.turnaround, out_data.turnaround);
          check_field("wait_time", e.wait_time, out_data.wait_time);
          check_field("response_valid", e.response_valid, out_data.response_valid);
          check_field("response_time", e.response_time, out_data.response_time);
          check_field("last", e.last, out_data.last);
        end
      end
      if (cfg_valid && cfg_ready) quantum = cfg_data;
      if (in_valid && in_ready) begin
        if (in_data.req_type == REQ_LOAD) load_proc(in_data);
        else slices_due.push_back(run_slice());
      end
    end
  end

endmodule

/* tb/tb_round_robin_quantum_scheduler.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_round_robin_quantum_scheduler
// Drives load and run requests and quantum writes into the scheduler with
// random idling on both channels; a checker beside the block predicts every
// slice result and counts mismatches for the final verdict.
// ----------------------------------------------------------------------------
module tb_round_robin_quantum_scheduler;
  import rrqs_pkg::*;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  req_t        in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  res_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [15:0] cfg_data = '0;

  int errors, pending, slices_checked;
  int send_idle = 24, recv_idle = 63;
  int sent = 0, loads = 0, cfg_writes = 0;
  logic [31:0] arr_ptr = '0;

  round_robin_quantum_scheduler dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  round_robin_quantum_scheduler_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .slices_checked(slices_checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result side stalls
  always @(posedge clk) out_ready <= ($urandom_range(99) >= recv_idle);

  task automatic send(req_t r);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic load(logic [6:0] id, logic [31:0] arr, logic [31:0] burst,
                      logic [31:0] ofs);
    req_t r;
    r = '{req_type: REQ_LOAD, process_id: id, arrival_time: arr,
          burst_time: burst, first_response_offset: ofs};
    loads++;
    send(r);
  endtask

  // run request with random don't-care fields
  task automatic run_slice_req();
    req_t r;
    r = '{req_type: REQ_RUN, process_id: $urandom, arrival_time: $urandom,
          burst_time: $urandom, first_response_offset: $urandom};
    send(r);
  endtask

  // quantum write once every slice has come back and the block has settled
  task automatic set_quantum(logic [15:0] q);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= q;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  // random load: mostly short bursts near the arrival pointer
  task automatic random_load();
    logic [6:0]  id;
    logic [31:0] arr, burst, ofs;
    id = ($urandom_range(9) == 0) ? 7'($urandom) : 7'($urandom_range(1, 64));
    arr_ptr += $urandom_range(0, 20);
    arr = ($urandom_range(9) == 0) ? arr_ptr - $urandom_range(0, 30) : arr_ptr;
    case ($urandom_range(19))
      0:       burst = 32'd0;
      1:       burst = $urandom;
      default: burst = $urandom_range(1, 40);
    endcase
    ofs = ($urandom_range(7) == 0) ? $urandom : $urandom_range(0, 50);
    load(id, arr, burst, ofs);
  endtask

  initial begin
    logic [15:0] q;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty scheduler, extremes, zero burst, late earlier arrival
    run_slice_req();
    load(7'd1, 32'd0, 32'd0, 32'd0);
    load(7'd64, 32'd0, 32'd1, 32'hFFFF_FFFF);
    load(7'd127, 32'd3, 32'd10, 32'd2);
    load(7'd0, 32'd5, 32'd7, 32'd0);
    load(7'd42, 32'd2, 32'd6, 32'd3);
    load(7'd85, 32'd100, 32'd9, 32'd8);
    repeat (10) run_slice_req();
    set_quantum(16'd0);
    repeat (4) run_slice_req();
    set_quantum(16'hFFFF);
    load(7'd21, 32'd120, 32'hFFFF_FFFF, 32'd70000);
    repeat (3) run_slice_req();
    arr_ptr = 32'd130;

    // random phases with a fresh quantum each
    for (int ph = 0; ph < 8; ph++) begin
      if (ph == 3) begin send_idle = 63; recv_idle = 24; end
      if (ph == 6) begin send_idle = 0; recv_idle = 0; end
      case (ph % 4)
        0: q = 16'd1;
        1: q = 16'($urandom_range(2, 8));
        2: q = ($urandom_range(1) != 0) ? 16'($urandom) : 16'hFFFF;
        default: q = 16'($urandom_range(0, 12));
      endcase
      set_quantum(q);
      for (int k = 0; k < 70; k++) begin
        if (loads < 60 && $urandom_range(99) < 14) random_load();
        else run_slice_req();
      end
    end

    // time near the top of the range, then loads past a full table
    set_quantum(16'hFFFF);
    load(7'd9, 32'hFFFF_FF00, 32'd300, 32'd5);
    load(7'd10, {1'b1, 31'($urandom)}, 32'd2, 32'd1);
    load(7'd11, 32'hFFFF_FFFF, 32'd0, 32'd0);
    while (loads < 64) load(7'd12, 32'hFFFF_FFFE, 32'd4, $urandom);
    repeat (3) load(7'd13, 32'd0, 32'd1, 32'd0);
    repeat (20) run_slice_req();

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("Sent %0d requests (%0d loads), checked %0d slice results",
             sent, loads, slices_checked);
    $display("over %0d quantum settings and three idling patterns", cfg_writes);
    if (errors == 0 && pending == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // run time guard
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
